[sv/icwl_pkg.sv]
// shared types and constants for the ids channel word likelihood block
// no dependencies
package icwl_pkg;

    localparam int unsigned VAL_W  = 32;   // lattice value, q1.31
    localparam int unsigned WGT_W  = 17;   // weight, q1.16
    localparam int unsigned PROD_W = 33;   // product after the 16-bit shift
    localparam int unsigned SUM_W  = 35;   // sum of three products
    localparam int unsigned IDX_W  = 3;    // register index width

    localparam logic [VAL_W-1:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h1_0000;

    // register indexes
    localparam logic [IDX_W-1:0] REG_INS_NONE = 3'd0;
    localparam logic [IDX_W-1:0] REG_INS_ONE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INS_TWO  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DEL      = 3'd3;
    localparam logic [IDX_W-1:0] REG_SUB_SAME = 3'd4;
    localparam logic [IDX_W-1:0] REG_SUB_DIFF = 3'd5;

    // action codes
    localparam logic ACT_DIRECT = 1'b0;
    localparam logic ACT_NEIGH  = 1'b1;

    localparam logic [1:0] NB_LAST = 2'd3;

    typedef struct packed {
        logic [WGT_W-1:0] ins_none;
        logic [WGT_W-1:0] ins_one;
        logic [WGT_W-1:0] ins_two;
        logic [WGT_W-1:0] del;
        logic [WGT_W-1:0] sub_same;
        logic [WGT_W-1:0] sub_diff;
    } weights_t;

    typedef struct packed {
        logic init;      // load start value of row 0
        logic mul_en;    // register the three products
        logic add_en;    // sum, saturate and store
        logic sent_bit;  // sent symbol of the current row
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

[sv/ids_channel_word_likelihood.sv]
// top level: config registers, sequencer and the row of lattice cells
// depends on icwl_pkg and icwl_cell
//
// channel  | ports                       | contents
// s_axis   | tvalid tready tdata tuser   | sent_word, recv_word; tuser action
// m_axis   | tvalid tready tdata         | likelihood q1.31
// cfg      | valid ready index data      | weight registers, ready out of reset
//
// each lattice row is a multiply state and then an add state across all
// WORD_BITS+1 cells; after the last row comes a compare state.
// action 0 takes one lattice, action 1 four; a word is accepted in the idle state.
// reset is synchronous on aresetn; weights return to their reset values.
// a new word is taken once the previous one has reached the output register;
// a stalled output holds the block in its compare cycle.
module ids_channel_word_likelihood #(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] sent_word, [15:8] recv_word
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] likelihood
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import icwl_pkg::*;

    localparam int unsigned N  = WORD_BITS;
    localparam int unsigned SW = (N > 1) ? $clog2(N) : 1;

    weights_t         wgt_reg;
    state_t           state_reg, state_next;
    logic             act_reg;
    logic [N-1:0]     sent_reg, recv_reg;
    logic [1:0]       nb_reg;
    logic [SW-1:0]    row_reg;
    logic [VAL_W-1:0] best_reg, best_next, out_reg;
    logic             out_valid_reg;
    logic [WGT_W-1:0] cfg_v;
    logic [15:0]      sent_ext, recv_ext;
    logic [N-1:0]     sent_in, recv_in, nb_word, cur_recv;
    logic [VAL_W-1:0] vals [0:N];
    cell_ctrl_t       ctrl;
    logic             s_fire, last_row, last_lat, out_free;
    logic             load_item, start_lat, nb_inc, out_load, row_inc;

    // configuration, clamped to one
    assign cfg_ready = aresetn;
    assign cfg_v = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_reg.ins_none <= '0;
            wgt_reg.ins_one  <= '0;
            wgt_reg.ins_two  <= '0;
            wgt_reg.del      <= '0;
            wgt_reg.sub_same <= ONE_Q16;
            wgt_reg.sub_diff <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INS_NONE: wgt_reg.ins_none <= cfg_v;
                REG_INS_ONE:  wgt_reg.ins_one  <= cfg_v;
                REG_INS_TWO:  wgt_reg.ins_two  <= cfg_v;
                REG_DEL:      wgt_reg.del      <= cfg_v;
                REG_SUB_SAME: wgt_reg.sub_same <= cfg_v;
                REG_SUB_DIFF: wgt_reg.sub_diff <= cfg_v;
                default: ;
            endcase
        end
    end

    // input words masked to WORD_BITS symbols
    assign sent_ext = {8'd0, s_axis_tdata[7:0]};
    assign recv_ext = {8'd0, s_axis_tdata[15:8]};

    always_comb begin
        for (int i = 0; i < N; i++) begin
            sent_in[i] = sent_ext[i];
            recv_in[i] = recv_ext[i];
        end
    end

    // neighbour of the received word for this pass
    always_comb begin
        case (nb_reg)
            2'd0:    nb_word = recv_reg >> 1;
            2'd1:    nb_word = (recv_reg >> 1) | (N'(1) << (N - 1));
            2'd2:    nb_word = recv_reg << 1;
            default: nb_word = (recv_reg << 1) | N'(1);
        endcase
        cur_recv = (act_reg == ACT_DIRECT) ? recv_reg : nb_word;
    end

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign last_row  = (row_reg == SW'(N - 1));
    assign last_lat  = (act_reg == ACT_DIRECT) || (nb_reg == NB_LAST);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign best_next = (vals[N] > best_reg) ? vals[N] : best_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  if (last_row) state_next = ST_DONE; else state_next = ST_MUL;
            ST_DONE: begin
                if (!last_lat) state_next = ST_MUL;
                else if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        load_item     = 1'b0;
        start_lat     = 1'b0;
        nb_inc        = 1'b0;
        out_load      = 1'b0;
        row_inc       = 1'b0;
        ctrl.mul_en   = 1'b0;
        ctrl.add_en   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = aresetn;
                load_item     = s_fire;
                start_lat     = s_fire;
            end
            ST_MUL: ctrl.mul_en = 1'b1;
            ST_ADD: begin
                ctrl.add_en = 1'b1;
                row_inc     = 1'b1;
            end
            ST_DONE: begin
                if (!last_lat) begin
                    nb_inc    = 1'b1;
                    start_lat = 1'b1;
                end else begin
                    out_load = out_free;
                end
            end
            default: ;
        endcase
        ctrl.init     = start_lat;
        ctrl.sent_bit = sent_reg[row_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    // item and pass registers
    always_ff @(posedge aclk) begin
        if (load_item) begin
            act_reg  <= s_axis_tuser;
            sent_reg <= sent_in;
            recv_reg <= recv_in;
            nb_reg   <= '0;
            best_reg <= '0;
        end else if (nb_inc) begin
            nb_reg   <= nb_reg + 2'd1;
            best_reg <= best_next;
        end
        if (start_lat) row_reg <= '0;
        else if (row_inc && !last_row) row_reg <= row_reg + SW'(1);
        if (out_load) out_reg <= best_next;
    end

    // row of cells, one per received position
    for (genvar t = 0; t <= N; t++) begin : g_cell
        icwl_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .wgt      (wgt_reg),
            .init_val ((t == 0) ? ONE_Q31 : '0),
            .nb1_val  ((t >= 1) ? vals[(t >= 1) ? t - 1 : 0] : '0),
            .nb2_val  ((t >= 2) ? vals[(t >= 2) ? t - 2 : 0] : '0),
            .b1       ((t >= 1) ? cur_recv[(t >= 1) ? t - 1 : 0] : 1'b0),
            .b2       ((t >= 2) ? cur_recv[(t >= 2) ? t - 2 : 0] : 1'b0),
            .val      (vals[t])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    ap_start : assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_MUL && nb_reg == 2'd0 && row_reg == '0)
        else $error("pass did not start cleanly");

    ap_rows : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD && last_row |=> state_reg == ST_DONE)
        else $error("lattice did not finish after last row");

    ap_range : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_reg <= ONE_Q31)
        else $error("likelihood above one");

    ap_nb : assert property (@(posedge aclk) disable iff (!aresetn)
        act_reg == ACT_DIRECT && state_reg != ST_IDLE |-> nb_reg == 2'd0)
        else $error("neighbour pass in direct mode");

endmodule

[sv/icwl_cell.sv]
// one lattice column: holds its value and updates it row by row
// depends on icwl_pkg
module icwl_cell (
    input  logic                     aclk,
    input  icwl_pkg::cell_ctrl_t     ctrl,
    input  icwl_pkg::weights_t       wgt,
    input  logic [31:0]              init_val,
    input  logic [31:0]              nb1_val,   // column t-1
    input  logic [31:0]              nb2_val,   // column t-2
    input  logic                     b1,        // received symbol t-1
    input  logic                     b2,        // received symbol t-2
    output logic [31:0]              val
);
    import icwl_pkg::*;

    logic [VAL_W-1:0]  val_reg;
    logic [PROD_W-1:0] p_del_reg, p_sub_reg, p_ins_reg;
    logic [WGT_W-1:0]  w_sub, w_ins;
    logic [1:0]        ndiff;
    logic [48:0]       m_del, m_sub, m_ins;
    logic [SUM_W-1:0]  sum;

    // weight selection by symbol mismatch
    always_comb begin
        ndiff = {1'b0, ctrl.sent_bit ^ b1} + {1'b0, ctrl.sent_bit ^ b2};
        w_sub = (ctrl.sent_bit ^ b1) ? wgt.sub_diff : wgt.sub_same;
        case (ndiff)
            2'd0:    w_ins = wgt.ins_none;
            2'd1:    w_ins = wgt.ins_one;
            default: w_ins = wgt.ins_two;
        endcase
    end

    assign m_del = 49'(val_reg) * 49'(wgt.del);
    assign m_sub = 49'(nb1_val) * 49'(w_sub);
    assign m_ins = 49'(nb2_val) * 49'(w_ins);

    assign sum = SUM_W'(p_del_reg) + SUM_W'(p_sub_reg) + SUM_W'(p_ins_reg);

    // products, then saturated sum
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_del_reg <= m_del[48:16];
            p_sub_reg <= m_sub[48:16];
            p_ins_reg <= m_ins[48:16];
        end
        if (ctrl.init) begin
            val_reg <= init_val;
        end else if (ctrl.add_en) begin
            val_reg <= (sum > SUM_W'(ONE_Q31)) ? ONE_Q31 : sum[VAL_W-1:0];
        end
    end

    assign val = val_reg;

    ap_sat : assert property (@(posedge aclk)
        $past(ctrl.add_en) && !$past(ctrl.init) |-> val_reg <= ONE_Q31)
        else $error("cell value above one");

    ap_excl : assert property (@(posedge aclk) !(ctrl.mul_en && ctrl.add_en))
        else $error("multiply and add in the same cycle");

    ap_init : assert property (@(posedge aclk) ctrl.init |=> val_reg == $past(init_val))
        else $error("cell start value not loaded");

endmodule

[tb/tb_likelihood_checker.sv]
`timescale 1ns / 100ps
// checker for the ids channel word likelihood block: watches the config, input
// and result channels, predicts each likelihood and compares; needs icwl_pkg
module tb_likelihood_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    import icwl_pkg::*;

    localparam int unsigned NB = 8;

    logic [16:0] w_ins_none, w_ins_one, w_ins_two, w_del, w_same, w_diff;
    logic [31:0] likelihood_queue[$];

    assign pending_count = likelihood_queue.size();

    function automatic logic [63:0] scale(logic [63:0] v, logic [16:0] w);
        return (v * {47'd0, w}) >> 16;
    endfunction

    // forward lattice over the channel, row by row
    function automatic logic [31:0] word_likelihood(logic [7:0] sent, logic [7:0] recv);
        logic [63:0] prev[NB+1];
        logic [63:0] cur[NB+1];
        logic [63:0] acc;
        logic [16:0] w;
        logic a, b1, b2;
        int d;
        for (int t = 0; t <= NB; t++) prev[t] = 0;
        prev[0] = 64'(ONE_Q31);
        for (int s = 1; s <= NB; s++) begin
            a = sent[s-1];
            for (int t = 0; t <= NB; t++) begin
                acc = scale(prev[t], w_del);
                if (t >= 1) begin
                    b1 = recv[t-1];
                    acc += scale(prev[t-1], (a != b1) ? w_diff : w_same);
                    if (t >= 2) begin
                        b2 = recv[t-2];
                        d = int'(a != b1) + int'(a != b2);
                        w = (d == 0) ? w_ins_none : (d == 1) ? w_ins_one : w_ins_two;
                        acc += scale(prev[t-2], w);
                    end
                end
                cur[t] = (acc > 64'(ONE_Q31)) ? 64'(ONE_Q31) : acc;
            end
            for (int t = 0; t <= NB; t++) prev[t] = cur[t];
        end
        return prev[NB][31:0];
    endfunction

    function automatic logic [31:0] neighbour_max(logic [7:0] sent, logic [7:0] recv);
        logic [7:0] nb[4];
        logic [31:0] best, p;
        nb[0] = recv >> 1;
        nb[1] = (recv >> 1) | 8'h80;
        nb[2] = recv << 1;
        nb[3] = (recv << 1) | 8'h01;
        best = 0;
        for (int i = 0; i < 4; i++) begin
            p = word_likelihood(sent, nb[i]);
            if (p > best) best = p;
        end
        return best;
    endfunction

    // register writes, input words and result words
    always @(posedge aclk) begin
        logic [16:0] v;
        logic [31:0] exp_val;
        if (!aresetn) begin
            w_ins_none <= 0; w_ins_one <= 0; w_ins_two <= 0;
            w_del <= 0; w_same <= ONE_Q16; w_diff <= 0;
            likelihood_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                v = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
                case (cfg_index)
                    REG_INS_NONE: w_ins_none <= v;
                    REG_INS_ONE:  w_ins_one  <= v;
                    REG_INS_TWO:  w_ins_two  <= v;
                    REG_DEL:      w_del      <= v;
                    REG_SUB_SAME: w_same     <= v;
                    REG_SUB_DIFF: w_diff     <= v;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_DIRECT)
                    likelihood_queue.push_back(
                        word_likelihood(s_axis_tdata[7:0], s_axis_tdata[15:8]));
                else
                    likelihood_queue.push_back(
                        neighbour_max(s_axis_tdata[7:0], s_axis_tdata[15:8]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (likelihood_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_val = likelihood_queue.pop_front();
                    if (exp_val !== m_axis_tdata) begin
                        if (fail_count < 10)
                            $display("likelihood mismatch: expected %h actual %h",
                                     exp_val, m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// top of the ids channel word likelihood testbench: clock, reset, stimulus
// and verdict; needs icwl_pkg, the block and tb_likelihood_checker
module tb_top;
    import icwl_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    int          fail_count;
    int          pending_count;
    bit          calm = 1'b0;     // no idling on either side
    bit          hold_off = 1'b0; // long receiver stall

    always #2 aclk = ~aclk;

    ids_channel_word_likelihood #(.WORD_BITS(8)) i_dut (.*);

    tb_likelihood_checker i_checker (.*);

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 7);
    end

    initial begin
        repeat (30) @(posedge aclk);
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_weights(logic [16:0] a, logic [16:0] b, logic [16:0] c,
                               logic [16:0] d, logic [16:0] e, logic [16:0] f);
        write_reg(REG_INS_NONE, a); write_reg(REG_INS_ONE, b);
        write_reg(REG_INS_TWO, c);  write_reg(REG_DEL, d);
        write_reg(REG_SUB_SAME, e); write_reg(REG_SUB_DIFF, f);
    endtask

    task automatic send_word(logic act, logic [7:0] sent, logic [7:0] recv);
        while (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1; s_axis_tuser <= act; s_axis_tdata <= {recv, sent};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'h1_FFFF;
            default: return 17'($urandom_range(17'h1_FFFF));
        endcase
    endfunction

    initial begin
        logic [7:0] s;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset weights, then extremes
        send_word(ACT_DIRECT, 8'h00, 8'h00);
        send_word(ACT_DIRECT, 8'hFF, 8'hFF);
        send_word(ACT_DIRECT, 8'hA5, 8'hA5);
        send_word(ACT_DIRECT, 8'h00, 8'hFF);
        send_word(ACT_NEIGH, 8'h5A, 8'hB4);
        send_word(ACT_NEIGH, 8'hFF, 8'h00);
        drain();
        // all ones, above one too: saturation
        set_weights(ONE_Q16, 17'h1_FFFF, ONE_Q16, ONE_Q16, 17'h1_FFFF, ONE_Q16);
        send_word(ACT_DIRECT, 8'h00, 8'h00);
        send_word(ACT_DIRECT, 8'hFF, 8'h0F);
        send_word(ACT_NEIGH, 8'h3C, 8'hC3);
        send_word(ACT_NEIGH, 8'h81, 8'h7E);
        drain();
        set_weights(17'd3000, 17'd2000, 17'd1000, 17'd5000, 17'd60000, 17'd4000);
        send_word(ACT_DIRECT, 8'h12, 8'h24);
        send_word(ACT_DIRECT, 8'h12, 8'h09);
        send_word(ACT_NEIGH, 8'h12, 8'h12);
        send_word(ACT_NEIGH, 8'hF0, 8'h0F);
        drain();

        // random phases with changing weights
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            set_weights(rand_weight(), rand_weight(), rand_weight(),
                        rand_weight(), rand_weight(), rand_weight());
            for (int i = 0; i < 100; i++) begin
                s = 8'($urandom);
                // about half near matches so the lattice stays non-zero
                if ($urandom_range(1))
                    send_word(1'($urandom), s, s ^ (8'd1 << $urandom_range(7)));
                else
                    send_word(1'($urandom), s, 8'($urandom));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
